FILE: src/seeds_automaton_grid_step_top_macros.svh
// Assertion helpers for the seeds grid block checker.
`ifndef SEEDS_AUTOMATON_GRID_STEP_TOP_MACROS_SVH
`define SEEDS_AUTOMATON_GRID_STEP_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define SEEDS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("seeds grid check failed");

// next-cycle implication, off during reset
`define SEEDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("seeds grid check failed");

`endif

FILE: src/seeds_pkg.sv
package seeds_pkg;

  localparam int IDX_W            = 12;
  localparam int BIRTH_COUNT      = 2;
  localparam int DEF_GRID_WIDTH   = 64;
  localparam int DEF_GRID_HEIGHT  = 64;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_WAIT,
    ST_WR,
    ST_LOAD0,
    ST_LOAD1,
    ST_RUN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic rd_cell;
    logic wr_cell;
    logic step_init;
    logic step_load;
    logic step_run;
    logic clr_row;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic in_range;
    logic is_write;
    logic row_last;
    logic out_free;
  } stat_t;

endpackage

FILE: src/seeds_automaton_grid_step_top.sv
// A request is taken in ST_IDLE. A read or write runs ST_DIV and ST_RD, then,
// if in the grid, ST_WAIT and, for a write, ST_WR. A step runs ST_LOAD0, ST_LOAD1,
// then ST_RUN one row per cycle. Every request ends in ST_RESP, which waits while
// out_stall holds the last result. One request at a time; the next is taken the
// cycle after its result is registered. After reset a clearing pass zeroes each
// row with input stalled.
module seeds_automaton_grid_step_top
  import seeds_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       action,
  input  logic [IDX_W-1:0] cell_index,
  input  logic             cell_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             cell_alive,
  output logic             step_done
);

  cmd_t  cmd;
  stat_t st;

  seeds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .action   (action),
    .st       (st),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  seeds_dp #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .action     (action),
    .cell_index (cell_index),
    .cell_value (cell_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cell_alive (cell_alive),
    .step_done  (step_done)
  );

endmodule

FILE: src/seeds_ctrl.sv
module seeds_ctrl
  import seeds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] action,
  input  stat_t      st,
  output cmd_t       cmd,
  output logic       in_stall
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_row = 1'b1;
        if (st.row_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (action)
            ACT_WRITE, ACT_READ: state_next = ST_DIV;
            ACT_STEP:            state_next = ST_LOAD0;
            default:             state_next = ST_RESP;
          endcase
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_next   = ST_RD;
      end
      ST_RD: begin
        // drop out-of-grid requests without touching memory
        if (st.in_range) begin
          cmd.rd_cell = 1'b1;
          state_next  = ST_WAIT;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_WAIT: begin
        state_next = st.is_write ? ST_WR : ST_RESP;
      end
      ST_WR: begin
        cmd.wr_cell = 1'b1;
        state_next  = ST_RESP;
      end
      ST_LOAD0: begin
        cmd.step_init = 1'b1;
        state_next    = ST_LOAD1;
      end
      ST_LOAD1: begin
        cmd.step_load = 1'b1;
        state_next    = ST_RUN;
      end
      ST_RUN: begin
        cmd.step_run = 1'b1;
        if (st.row_last) state_next = ST_RESP;
      end
      ST_RESP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: src/seeds_dp.sv
module seeds_dp
  import seeds_pkg::*;
#(
  parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            st,
  input  logic [1:0]       action,
  input  logic [IDX_W-1:0] cell_index,
  input  logic             cell_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             cell_alive,
  output logic             step_done
);

  localparam int CW     = $clog2(GRID_WIDTH);
  localparam int RAW    = $clog2(GRID_HEIGHT);
  localparam int CNT_W  = RAW + 1;
  localparam int SHIFT  = IDX_W + $clog2(GRID_WIDTH);
  localparam int RECIP  = ((1 << SHIFT) + GRID_WIDTH - 1) / GRID_WIDTH;
  localparam int PROD_W = 2 * IDX_W + 1;

  logic [1:0]            act;
  logic                  val;
  logic [IDX_W-1:0]      idx;
  logic [IDX_W-1:0]      quot;
  logic [CNT_W-1:0]      row_cnt;
  logic [GRID_WIDTH-1:0] prev;
  logic [GRID_WIDTH-1:0] cur;
  logic [GRID_WIDTH-1:0] rdata;
  logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];

  logic [PROD_W-1:0]     prod;
  logic [IDX_W-1:0]      quot_w;
  logic [CW-1:0]         col;
  logic [RAW-1:0]        row_q;
  logic [CNT_W-1:0]      row_plus2;
  logic                  row_last;
  logic                  in_range;
  logic [GRID_WIDTH-1:0] nxt;
  logic [GRID_WIDTH-1:0] new_row;
  logic [GRID_WIDTH-1:0] mod_row;
  logic                  we;
  logic                  re;
  logic [RAW-1:0]        waddr;
  logic [RAW-1:0]        raddr;
  logic [GRID_WIDTH-1:0] wdata;

  // row from a rounded-up reciprocal, exact over the whole index range
  assign prod      = PROD_W'(idx) * PROD_W'(RECIP);
  assign quot_w    = quot * IDX_W'(GRID_WIDTH);
  assign col       = CW'(idx - quot_w);
  assign row_q     = quot[RAW-1:0];
  assign in_range  = 32'(quot) < 32'(GRID_HEIGHT);
  assign row_last  = row_cnt == CNT_W'(GRID_HEIGHT - 1);
  assign row_plus2 = row_cnt + CNT_W'(2);

  // below the bottom row everything is dead
  assign nxt = row_last ? '0 : rdata;

  always_comb begin
    logic [GRID_WIDTH+1:0] pp;
    logic [GRID_WIDTH+1:0] cp;
    logic [GRID_WIDTH+1:0] np;
    logic [3:0]            sum;
    pp = {1'b0, prev, 1'b0};
    cp = {1'b0, cur, 1'b0};
    np = {1'b0, nxt, 1'b0};
    for (int c = 0; c < GRID_WIDTH; c++) begin
      sum = 4'(pp[c]) + 4'(pp[c+1]) + 4'(pp[c+2]) + 4'(cp[c]) + 4'(cp[c+2])
          + 4'(np[c]) + 4'(np[c+1]) + 4'(np[c+2]);
      new_row[c] = !cur[c] && (sum == 4'(BIRTH_COUNT));
    end
  end

  always_comb begin
    mod_row      = rdata;
    mod_row[col] = val;
  end

  always_comb begin
    we    = 1'b0;
    waddr = row_cnt[RAW-1:0];
    wdata = '0;
    re    = 1'b0;
    raddr = row_q;
    if (cmd.clr_row) begin
      we = 1'b1;
    end
    if (cmd.step_run) begin
      we    = 1'b1;
      wdata = new_row;
      re    = row_plus2 < CNT_W'(GRID_HEIGHT);
      raddr = row_plus2[RAW-1:0];
    end
    if (cmd.wr_cell) begin
      we    = 1'b1;
      waddr = row_q;
      wdata = mod_row;
    end
    if (cmd.rd_cell) begin
      re = 1'b1;
    end
    if (cmd.step_init) begin
      re    = 1'b1;
      raddr = '0;
    end
    if (cmd.step_load) begin
      re    = 1'b1;
      raddr = RAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= action;
      val <= cell_value;
      idx <= cell_index;
    end
    if (cmd.div_step) quot <= IDX_W'(prod >> SHIFT);
    if (cmd.step_init) prev <= '0;
    if (cmd.step_load) cur <= rdata;
    if (cmd.step_run) begin
      // keep the old row above; memory now holds its new value
      prev <= cur;
      cur  <= rdata;
    end
    if (cmd.out_load) begin
      cell_alive <= (act == ACT_READ) && in_range && rdata[col];
      step_done  <= act == ACT_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.step_init) begin
        row_cnt <= '0;
      end else if (cmd.step_run || cmd.clr_row) begin
        row_cnt <= row_last ? '0 : row_cnt + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.in_range = in_range;
  assign st.is_write = act == ACT_WRITE;
  assign st.row_last = row_last;
  assign st.out_free = !out_valid || !out_stall;

endmodule

FILE: src/seeds_chk.sv
`include "seeds_automaton_grid_step_top_macros.svh"

module seeds_chk
  import seeds_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic [1:0]       action,
  input logic [IDX_W-1:0] cell_index,
  input logic             cell_value,
  input logic             out_valid,
  input logic             out_stall,
  input logic             cell_alive,
  input logic             step_done
);

  // one request in flight: busy right after an accept
  `SEEDS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a stalled request holds
  `SEEDS_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
                     in_valid && $stable(action) && $stable(cell_index) && $stable(cell_value))
  // a result is a read answer or a step completion, never both
  `SEEDS_ASSERT_IMPL(a_one_kind, out_valid, !(cell_alive && step_done))
  // a stalled result holds
  `SEEDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                     out_valid && $stable(cell_alive) && $stable(step_done))

endmodule

bind seeds_automaton_grid_step_top seeds_chk u_chk (.*);

FILE: tb/sv/seeds_automaton_grid_step_top_test.sv
`timescale 1ns / 100ps

module seeds_automaton_grid_step_top_test
  import seeds_pkg::*;
();

  localparam int GRID_W = DEF_GRID_WIDTH;
  localparam int GRID_H = DEF_GRID_HEIGHT;
  localparam int CELL_COUNT = GRID_W * GRID_H;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 140;
  localparam int IDLE_PERCENT = 38;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic alive;
    logic done;
  } cell_result_t;

  typedef struct packed {
    logic [1:0]       act;
    logic [IDX_W-1:0] idx;
    logic             val;
    logic             typed;
    logic             alive;
    logic             done;
  } grid_request_t;

  // typed rows carry the expected result; the others go through the predictor
  localparam int DIRECTED_COUNT = 24;
  localparam grid_request_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{ACT_READ,   12'd0,    1'b0, 1'b1, 1'b0, 1'b0},
    '{ACT_READ,   12'd4095, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,  12'd0,    1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_READ,   12'd0,    1'b0, 1'b1, 1'b1, 1'b0},
    '{ACT_WRITE,  12'd0,    1'b0, 1'b1, 1'b0, 1'b0},
    '{ACT_READ,   12'd0,    1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,  12'd0,    1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,  12'd2,    1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,  12'd63,   1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,  12'd4032, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,  12'd4093, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_WRITE,  12'd4095, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_READ,   12'd4095, 1'b0, 1'b1, 1'b1, 1'b0},
    '{ACT_UNUSED, 12'd4095, 1'b1, 1'b1, 1'b0, 1'b0},
    '{ACT_READ,   12'd0,    1'b0, 1'b1, 1'b1, 1'b0},
    '{ACT_STEP,   12'd4095, 1'b1, 1'b1, 1'b0, 1'b1},
    '{ACT_READ,   12'd1,    1'b0, 1'b0, 1'b0, 1'b0},
    '{ACT_READ,   12'd65,   1'b1, 1'b0, 1'b0, 1'b0},
    '{ACT_READ,   12'd0,    1'b0, 1'b0, 1'b0, 1'b0},
    '{ACT_READ,   12'd4094, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ACT_READ,   12'd4030, 1'b0, 1'b0, 1'b0, 1'b0},
    '{ACT_READ,   12'd62,   1'b0, 1'b0, 1'b0, 1'b0},
    '{ACT_STEP,   12'd0,    1'b0, 1'b1, 1'b0, 1'b1},
    '{ACT_READ,   12'd64,   1'b0, 1'b0, 1'b0, 1'b0}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       action = ACT_WRITE;
  logic [IDX_W-1:0] cell_index = '0;
  logic             cell_value = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             cell_alive;
  logic             step_done;

  bit           seeds_grid [CELL_COUNT];
  cell_result_t pending_results [$];
  int           fail_count = 0;
  int           request_count = 0;
  bit           no_idle_stretch = 1'b0;

  seeds_automaton_grid_step_top #(
    .GRID_WIDTH (GRID_W),
    .GRID_HEIGHT(GRID_H)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .cell_index(cell_index),
    .cell_value(cell_value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_alive(cell_alive),
    .step_done (step_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic cell_result_t predict_request(input logic [1:0] act,
                                                   input logic [IDX_W-1:0] idx,
                                                   input logic val);
    cell_result_t res;
    bit           next_grid [CELL_COUNT];
    int           r, c, dr, dc, live;
    res = '0;
    case (act)
      ACT_WRITE: begin
        if (idx < CELL_COUNT) seeds_grid[idx] = val;
      end
      ACT_READ: begin
        if (idx < CELL_COUNT) res.alive = seeds_grid[idx];
      end
      ACT_STEP: begin
        for (r = 0; r < GRID_H; r++) begin
          for (c = 0; c < GRID_W; c++) begin
            live = 0;
            for (dr = -1; dr <= 1; dr++) begin
              for (dc = -1; dc <= 1; dc++) begin
                // cells off the grid stay dead, no wrap
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_H &&
                    c + dc >= 0 && c + dc < GRID_W)
                  live += seeds_grid[(r + dr) * GRID_W + c + dc];
              end
            end
            next_grid[r * GRID_W + c] = !seeds_grid[r * GRID_W + c] && live == BIRTH_COUNT;
          end
        end
        seeds_grid = next_grid;
        res.done = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  function automatic int edge_biased_coord();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? GRID_H - 1 : 0;
    return $urandom_range(0, GRID_H - 1);
  endfunction

  function automatic logic [IDX_W-1:0] cell_at(input int r, input int c);
    if (r < 0) r = 0;
    if (r > GRID_H - 1) r = GRID_H - 1;
    if (c < 0) c = 0;
    if (c > GRID_W - 1) c = GRID_W - 1;
    return IDX_W'(r * GRID_W + c);
  endfunction

  task automatic send_request(input logic [1:0] act, input logic [IDX_W-1:0] idx,
                              input logic val, input bit typed = 1'b0,
                              input cell_result_t typed_res = '0);
    cell_result_t res;
    if (!no_idle_stretch) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    action     <= act;
    cell_index <= idx;
    cell_value <= val;
    do @(posedge clk); while (in_stall);
    res = predict_request(act, idx, val);
    pending_results.push_back(typed ? typed_res : res);
    if (act != ACT_UNUSED) request_count++;
  endtask

  task automatic wait_for_all_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cell_result_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: alive %0d done %0d",
                               cell_alive, step_done));
      end else begin
        exp_res = pending_results.pop_front();
        if (exp_res.alive !== cell_alive || exp_res.done !== step_done)
          note_failure($sformatf("mismatch: expected alive %0d done %0d, got alive %0d done %0d",
                                 exp_res.alive, exp_res.done, cell_alive, step_done));
      end
    end
    out_stall <= !no_idle_stretch && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  initial begin
    grid_request_t row;
    int            pick, base_r, base_c;
    bit            drained_midway;
    drained_midway = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      row = DIRECTED_ROWS[i];
      send_request(row.act, row.idx, row.val, row.typed, '{alive: row.alive, done: row.done});
    end
    wait_for_all_results();

    while (request_count < ITEM_TARGET) begin
      no_idle_stretch = request_count >= 40 && request_count < 70;
      // hold off once until the block has answered everything
      if (!drained_midway && request_count >= 95) begin
        wait_for_all_results();
        drained_midway = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // seed a small cluster, advance, then probe around it
        base_r = edge_biased_coord();
        base_c = edge_biased_coord();
        repeat ($urandom_range(2, 4))
          send_request(ACT_WRITE, cell_at(base_r + int'($urandom_range(0, 2)) - 1,
                                          base_c + int'($urandom_range(0, 2)) - 1),
                       $urandom_range(0, 4) != 0);
        repeat ($urandom_range(1, 2))
          send_request(ACT_STEP, IDX_W'($urandom_range(0, CELL_COUNT - 1)),
                       1'($urandom_range(0, 1)));
        repeat ($urandom_range(3, 5))
          send_request(ACT_READ, cell_at(base_r + int'($urandom_range(0, 4)) - 2,
                                         base_c + int'($urandom_range(0, 4)) - 2),
                       1'($urandom_range(0, 1)));
      end else if (pick < 9) begin
        repeat (2)
          send_request(ACT_READ, IDX_W'($urandom_range(0, CELL_COUNT - 1)),
                       1'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 1)) begin
        send_request(ACT_UNUSED, IDX_W'($urandom_range(0, CELL_COUNT - 1)),
                     1'($urandom_range(0, 1)));
      end else begin
        send_request(ACT_WRITE, IDX_W'($urandom_range(0, CELL_COUNT - 1)),
                     1'($urandom_range(0, 1)));
      end
    end

    wait_for_all_results();
    repeat (GRID_H + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/seeds_pkg.sv
src/seeds_ctrl.sv
src/seeds_dp.sv
src/seeds_automaton_grid_step_top.sv
src/seeds_chk.sv
tb/sv/seeds_automaton_grid_step_top_test.sv
